>>> hw/rtl/sapq_pkg.sv
// Shared types and constants for the sorted array priority queue.
`timescale 1ns / 1ps
`default_nettype none
package sapq_pkg;

    localparam int DEPTH       = 16;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int OUT_CNT_W   = 5;
    localparam int FUNC_W      = 2;
    localparam int STAT_W      = 2;
    localparam int OUT_TDATA_W = 40;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVF   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // One move per cycle, broadcast to every cell of the row.
    typedef struct packed {
        logic insert;
        logic remove;
        logic rotate;
    } t_cell_ctrl;

endpackage
`default_nettype wire

>>> hw/rtl/sapq_cell.sv
// One storage cell of the sorted row: holds an entry, moves it per broadcast command.
`timescale 1ns / 1ps
`default_nettype none
module sapq_cell (
    input  wire                              i_clk,
    input  wire sapq_pkg::t_cell_ctrl        i_ctrl,
    input  wire signed [sapq_pkg::DATA_W-1:0] i_new_value,
    input  wire signed [sapq_pkg::DATA_W-1:0] i_left_value,
    input  wire                              i_left_stay,
    input  wire signed [sapq_pkg::DATA_W-1:0] i_right_value,
    input  wire signed [sapq_pkg::DATA_W-1:0] i_head_value,
    input  wire                              i_occ,
    input  wire                              i_tail,
    output logic signed [sapq_pkg::DATA_W-1:0] o_value,
    output logic                             o_stay
);

    logic signed [sapq_pkg::DATA_W-1:0] r_value;
    logic signed [sapq_pkg::DATA_W-1:0] n_value;

    // Keep the entry on insert when it is at least the new value.
    assign o_stay  = i_occ && (r_value >= i_new_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.insert) begin
            if (!o_stay) begin
                n_value = i_left_stay ? i_new_value : i_left_value;
            end
        end else if (i_ctrl.remove) begin
            n_value = i_right_value;
        end else if (i_ctrl.rotate) begin
            n_value = i_tail ? i_head_value : i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
`default_nettype wire

>>> hw/rtl/sorted_array_priority_queue_unit.sv
// Top level of the sorted array priority queue: control, cell row and output register.
`timescale 1ns / 1ps
`default_nettype none
// Bounded priority queue of sapq_pkg::DEPTH signed 32-bit entries, held largest first in a
// row of cells. Each input word carries an operation in tuser (0 insert, 1 remove largest,
// 2 dump) and a value in tdata. On insert and remove every cell compares the new value with
// its own entry and its left neighbor's decision, then keeps, takes the new value or shifts,
// all in the same edge; equal values leave in arrival order. Each returns one result word. A
// dump first enters the dump state; then, while the output register is free, the row rotates
// one place per cycle, the head goes out, and after count steps the row is back in order; the
// input side is held off meanwhile and the last entry carries tlast. An empty dump or remove
// returns one word with status empty; an insert into a full queue returns status overflow and
// drops the value. Code 3 is taken and dropped with no result. The output register lets a new
// input word in while the previous result waits, as long as it is taken the same cycle. After
// reset the queue is empty; no clearing pass is needed.
module sorted_array_priority_queue_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire  [sapq_pkg::DATA_W-1:0]         i_s_axis_tdata,  // [31:0] value
    input  wire  [sapq_pkg::FUNC_W-1:0]         i_s_axis_tuser,  // [1:0] func
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    output logic [sapq_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,  // [31:0] value_res,
                                                                 // [36:32] count_after, pad
    output logic [sapq_pkg::STAT_W-1:0]         o_m_axis_tuser,  // [1:0] status
    output logic                                o_m_axis_tlast   // last
);

    localparam int D  = sapq_pkg::DEPTH;
    localparam int CW = sapq_pkg::CNT_W;
    localparam int DW = sapq_pkg::DATA_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } t_state;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_dump_left, n_dump_left;

    // Output register.
    logic                        r_out_valid;
    logic signed [DW-1:0]        r_out_value;
    logic [sapq_pkg::STAT_W-1:0] r_out_status;
    logic                        r_out_last;
    logic [CW-1:0]               r_out_count;

    logic                        w_emit;
    logic signed [DW-1:0]        w_emit_value;
    logic [sapq_pkg::STAT_W-1:0] w_emit_status;
    logic                        w_emit_last;
    logic [CW-1:0]               w_emit_count;

    logic                        w_out_free;
    logic                        w_accept;
    logic signed [DW-1:0]        w_new_value;
    sapq_pkg::t_cell_ctrl        w_ctrl;

    // Cell row wiring.
    logic signed [DW-1:0]        w_value [D];
    logic [D-1:0]                w_stay;
    logic [D-1:0]                w_occ;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_new_value     = i_s_axis_tdata;

    // Cells below the count are occupied.
    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            logic signed [DW-1:0] w_left;
            logic                 w_left_stay;
            logic signed [DW-1:0] w_right;
            logic                 w_tail;

            assign w_occ[g] = r_count > CW'(g);

            if (g == 0) begin : g_head
                assign w_left      = w_new_value;
                assign w_left_stay = 1'b1;
            end else begin : g_body
                assign w_left      = w_value[g-1];
                assign w_left_stay = w_stay[g-1];
            end

            if (g == D - 1) begin : g_end
                assign w_right = w_value[g];
                assign w_tail  = w_occ[g];
            end else begin : g_mid
                assign w_right = w_value[g+1];
                assign w_tail  = w_occ[g] && !(r_count > CW'(g + 1));
            end

            sapq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_new_value   (w_new_value),
                .i_left_value  (w_left),
                .i_left_stay   (w_left_stay),
                .i_right_value (w_right),
                .i_head_value  (w_value[0]),
                .i_occ         (w_occ[g]),
                .i_tail        (w_tail),
                .o_value       (w_value[g]),
                .o_stay        (w_stay[g])
            );
        end
    endgenerate

    // Sequencer: decode the accepted word, or advance a dump one entry per free slot.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_dump_left   = r_dump_left;
        w_ctrl        = '0;
        w_emit        = 1'b0;
        w_emit_value  = '0;
        w_emit_status = sapq_pkg::STAT_OK;
        w_emit_last   = 1'b1;
        w_emit_count  = r_count;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_s_axis_tuser)
                        sapq_pkg::FUNC_INSERT: begin
                            w_emit = 1'b1;
                            if (r_count == CW'(D)) begin
                                w_emit_status = sapq_pkg::STAT_OVF;
                            end else begin
                                w_ctrl.insert = 1'b1;
                                n_count       = r_count + 1'b1;
                                w_emit_count  = n_count;
                            end
                        end
                        sapq_pkg::FUNC_REMOVE: begin
                            w_emit = 1'b1;
                            if (r_count == '0) begin
                                w_emit_status = sapq_pkg::STAT_EMPTY;
                            end else begin
                                w_ctrl.remove = 1'b1;
                                w_emit_value  = w_value[0];
                                n_count       = r_count - 1'b1;
                                w_emit_count  = n_count;
                            end
                        end
                        sapq_pkg::FUNC_DUMP: begin
                            if (r_count == '0) begin
                                w_emit        = 1'b1;
                                w_emit_status = sapq_pkg::STAT_EMPTY;
                            end else begin
                                n_state     = ST_DUMP;
                                n_dump_left = r_count;
                            end
                        end
                        default: begin
                            // Unused code: drop the word.
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                if (w_out_free) begin
                    w_ctrl.rotate = 1'b1;
                    w_emit        = 1'b1;
                    w_emit_value  = w_value[0];
                    w_emit_last   = (r_dump_left == CW'(1));
                    n_dump_left   = r_dump_left - 1'b1;
                    if (r_dump_left == CW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_dump_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dump_left <= n_dump_left;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the output register; hold until a new word is loaded.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_value  <= w_emit_value;
            r_out_status <= w_emit_status;
            r_out_last   <= w_emit_last;
            r_out_count  <= w_emit_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(sapq_pkg::OUT_TDATA_W - DW - sapq_pkg::OUT_CNT_W){1'b0}},
                              sapq_pkg::OUT_CNT_W'(r_out_count), r_out_value};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    // The input side stays closed for the whole dump.
    a_dump_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |-> !o_s_axis_tready)
        else $error("input accepted during dump");

    // The count never exceeds the row.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(D))
        else $error("count beyond depth");

    // Entries still to dump stay within the stored count.
    a_dump_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |-> (r_dump_left != '0 && r_dump_left <= r_count))
        else $error("dump counter out of range");

    // An insert into a queue with room grows it by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_axis_tuser == sapq_pkg::FUNC_INSERT && r_count != CW'(D))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not advance count");

    // A new result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_out_free)
        else $error("result overwritten");

endmodule
`default_nettype wire
